### src/cpfr_pkg.sv
package cpfr_pkg;

    // Sizes of the frame and of the parameter burst.
    localparam int PARAM_COUNT   = 10;
    localparam int PAYLOAD_BYTES = 56;

    // The payload store holds 64 bytes, kept as 16 little-endian words.
    localparam int STORE_WORDS = 16;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int CNT_W       = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W       = 4;

    // Command and trailer byte codes.
    localparam logic [7:0] CMD_START_STOP = 8'h30;
    localparam logic [7:0] CMD_TELEMETRY  = 8'h31;
    localparam logic [7:0] CMD_READBACK   = 8'h32;
    localparam logic [7:0] CMD_FRAME      = 8'h33;
    localparam logic [7:0] FRAME_TRAILER  = 8'hAB;

    // Action codes of a result.
    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_START      = 2'd1;
    localparam logic [1:0] ACT_STOP       = 2'd2;
    localparam logic [1:0] ACT_PARAM_WORD = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       car_stopped;
    } cpfr_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        telemetry_enable;
        logic        readback_request;
        logic        beep_pulse;
        logic [3:0]  param_index;
        logic [31:0] param_word;
        logic        last;
    } cpfr_result_t;

    // Kind of result that the datapath loads into its output register.
    typedef enum logic [1:0] {
        OUT_COMMAND,
        OUT_PLAIN,
        OUT_WORD
    } cpfr_out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic           cnt_clear;
        logic           store_byte;
        logic           load_out;
        cpfr_out_kind_t out_kind;
        logic           burst_start;
        logic           burst_step;
    } cpfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_frame_cmd;
        logic is_trailer;
        logic count_full;
        logic idx_last;
        logic out_free;
    } cpfr_status_t;

endpackage

### src/cpfr_datapath.sv
module cpfr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpfr_pkg::cpfr_item_t  item,
    input  cpfr_pkg::cpfr_cmd_t   cmd,
    output cpfr_pkg::cpfr_status_t sts,
    output logic                  result_valid,
    input  logic                  result_stall,
    output cpfr_pkg::cpfr_result_t result
);
    import cpfr_pkg::*;

    logic [31:0]      store_mem [STORE_WORDS];
    logic [31:0]      rdata_reg;
    logic [WORD_AW-1:0] rd_addr;
    logic [WORD_AW-1:0] wr_addr;
    logic [1:0]       wr_lane;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             tel_reg, tel_next;
    logic             out_valid_reg, out_valid_next;
    cpfr_result_t     out_reg, out_next;

    logic [7:0]       rx;
    logic             is_telemetry;

    assign rx           = item.rx_byte;
    assign is_telemetry = (rx == CMD_TELEMETRY);

    assign sts.is_frame_cmd = (rx == CMD_FRAME);
    assign sts.is_trailer   = (rx == FRAME_TRAILER);
    assign sts.count_full   = (byte_count_reg == CNT_W'(PAYLOAD_BYTES));
    assign sts.idx_last     = (idx_reg == IDX_W'(PARAM_COUNT - 1));
    assign sts.out_free     = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Payload store: byte lanes of 32-bit words, one byte written per transfer.
    assign wr_addr = byte_count_reg[5:2];
    assign wr_lane = byte_count_reg[1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_mem[wr_addr][8 * wr_lane +: 8] <= rx;
        end
    end

    // During a burst the read register holds the word at idx_reg, read ahead of its use.
    always_comb
    begin
        if (cmd.burst_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.burst_step)
        begin
            rd_addr = WORD_AW'(idx_reg + 1'b1);
        end
        else
        begin
            rd_addr = WORD_AW'(idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (cmd.cnt_clear)
        begin
            byte_count_next = '0;
        end
        else if (cmd.store_byte)
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.burst_start)
        begin
            idx_next = '0;
        end
        else if (cmd.burst_step)
        begin
            idx_next = idx_reg + 1'b1;
        end

        tel_next = tel_reg;
        if (cmd.load_out && cmd.out_kind == OUT_COMMAND && is_telemetry)
        begin
            tel_next = !tel_reg;
        end

        out_next                  = '0;
        out_next.telemetry_enable = tel_reg;
        out_next.last             = 1'b1;
        case (cmd.out_kind)
            OUT_COMMAND:
            begin
                out_next.beep_pulse       = 1'b1;
                out_next.telemetry_enable = tel_next;
                out_next.readback_request = (rx == CMD_READBACK);
                if (rx == CMD_START_STOP)
                begin
                    out_next.action = item.car_stopped ? ACT_START : ACT_STOP;
                end
            end
            OUT_WORD:
            begin
                out_next.action           = ACT_PARAM_WORD;
                out_next.readback_request = 1'b1;
                out_next.param_index      = idx_reg;
                out_next.param_word       = rdata_reg;
                out_next.last             = sts.idx_last;
            end
            default:
            begin
                out_next.action = ACT_NONE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            idx_reg        <= '0;
            tel_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            idx_reg        <= idx_next;
            tel_reg        <= tel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    // The telemetry flag only moves on a command transfer of its code.
    a_tel_change: assert property (@(posedge clk) disable iff (!rst_n)
        (tel_reg != $past(tel_reg)) |->
            ($past(cmd.load_out) && $past(cmd.out_kind) == OUT_COMMAND))
        else $error("telemetry flag changed without a command");

    // Each burst step advances the word index by exactly one.
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.burst_step && !cmd.burst_start) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("burst index did not advance");

    // The payload count never runs past the frame length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(PAYLOAD_BYTES))
        else $error("payload count out of range");

endmodule

### src/cpfr_ctrl.sv
module cpfr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  cpfr_pkg::cpfr_status_t sts,
    output cpfr_pkg::cpfr_cmd_t    cmd
);
    import cpfr_pkg::*;

    typedef enum logic [1:0] {
        S_COMMAND,
        S_PAYLOAD,
        S_BURST
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign item_stall = (state_reg == S_BURST) || !sts.out_free;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.out_kind    = OUT_PLAIN;
        case (state_reg)
            S_COMMAND:
            begin
                if (take)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = OUT_COMMAND;
                    if (sts.is_frame_cmd)
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD:
            begin
                if (take)
                begin
                    if (!sts.count_full)
                    begin
                        cmd.store_byte = 1'b1;
                        cmd.load_out   = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_clear = 1'b1;
                        if (sts.is_trailer)
                        begin
                            cmd.burst_start = 1'b1;
                            state_next      = S_BURST;
                        end
                        else
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = S_COMMAND;
                        end
                    end
                end
            end
            S_BURST:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_kind   = OUT_WORD;
                    cmd.burst_step = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_COMMAND;
                    end
                end
            end
            default:
            begin
                state_next = S_COMMAND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COMMAND;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The output register is only loaded when it is free to take a result.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    // A valid trailer always leads into the word burst.
    a_burst_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.burst_start |=> (state_reg == S_BURST))
        else $error("burst start without burst state");

    // Leaving the burst happens only after the final word was loaded.
    a_burst_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BURST && state_next == S_COMMAND) |->
            (cmd.load_out && cmd.out_kind == OUT_WORD && sts.idx_last))
        else $error("burst ended early");

endmodule

### src/command_and_parameter_frame_receiver_top.sv
// Command and parameter frame receiver.
// The item channel (item_valid, item_stall, item) carries one received serial
// byte with the car_stopped flag; a transfer happens on a rising edge where
// item_valid is high and item_stall is low. The result channel (result_valid,
// result_stall, result) carries result items the same way.
// Every byte gives one result, held in the output register from the cycle
// after its transfer. A frame trailer of 0xAB after a full payload instead
// gives ten parameter-word results: each word is first read from the
// payload store into a read register and then loaded into the output
// register, one word per cycle while the sink keeps up, and no new byte is
// taken until the tenth word has been loaded. Other bytes can be taken one
// per cycle while the output register is free.
// A new byte is taken while the previous result still waits in the output
// register, unless that register is stalled and full.
// Reset clears the frame state, the payload count, the telemetry flag and the
// output valid; the payload store itself is not cleared.
// When the sink holds result_stall, the pending result stays unchanged and
// the block stalls its input until that result is taken.
module command_and_parameter_frame_receiver_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  cpfr_pkg::cpfr_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output cpfr_pkg::cpfr_result_t result
);
    import cpfr_pkg::*;

    // The controller sequences command, payload and burst phases; the
    // datapath owns the payload store, counters and the output register.
    cpfr_cmd_t    cmd;
    cpfr_status_t sts;

    cpfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    cpfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### verif/frame_receiver_checker.sv
`timescale 1ns / 100ps

module frame_receiver_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  cpfr_pkg::cpfr_item_t   item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  cpfr_pkg::cpfr_result_t result,
    output int                     fail_count,
    output int                     owed_count,
    output int                     results_checked,
    output int                     words_checked
);
    import cpfr_pkg::*;

    // Mirror of the receiver state.
    logic         frame_open;
    int           payload_count;
    logic [7:0]   payload_bytes [64];
    logic         telemetry_on;
    cpfr_result_t owed_results [$];
    cpfr_result_t wanted;

    task automatic owe_result(input logic [1:0] action, input logic readback,
                              input logic beep, input logic [3:0] index,
                              input logic [31:0] word, input logic is_last);
        cpfr_result_t r;
        r.action           = action;
        r.telemetry_enable = telemetry_on;
        r.readback_request = readback;
        r.beep_pulse       = beep;
        r.param_index      = index;
        r.param_word       = word;
        r.last             = is_last;
        owed_results.push_back(r);
    endtask

    task automatic predict_byte(input cpfr_item_t it);
        int          i;
        int          base;
        logic [31:0] word;
        logic [1:0]  action;
        logic        readback;
        if (frame_open)
        begin
            if (payload_count < PAYLOAD_BYTES)
            begin
                payload_bytes[payload_count % 64] = it.rx_byte;
                payload_count++;
                owe_result(ACT_NONE, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
            end
            else
            begin
                frame_open    = 1'b0;
                payload_count = 0;
                if (it.rx_byte == FRAME_TRAILER)
                begin
                    for (i = 0; i < PARAM_COUNT; i++)
                    begin
                        base = i * 4;
                        word = {payload_bytes[(base + 3) % 64],
                                payload_bytes[(base + 2) % 64],
                                payload_bytes[(base + 1) % 64],
                                payload_bytes[base % 64]};
                        owe_result(ACT_PARAM_WORD, 1'b1, 1'b0, 4'(i), word,
                                   i == PARAM_COUNT - 1);
                    end
                end
                else
                begin
                    owe_result(ACT_NONE, 1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
                end
            end
        end
        else
        begin
            action   = ACT_NONE;
            readback = 1'b0;
            case (it.rx_byte)
                CMD_START_STOP: action = it.car_stopped ? ACT_START : ACT_STOP;
                CMD_TELEMETRY:  telemetry_on = ~telemetry_on;
                CMD_READBACK:   readback = 1'b1;
                CMD_FRAME:
                begin
                    frame_open    = 1'b1;
                    payload_count = 0;
                end
                default:        ;
            endcase
            owe_result(action, readback, 1'b1, 4'd0, 32'd0, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d, %s: expected 0x%0h, actual 0x%0h",
                     $time, results_checked, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open      = 1'b0;
            payload_count   = 0;
            telemetry_on    = 1'b0;
            owed_results.delete();
            fail_count      = 0;
            owed_count      = 0;
            results_checked = 0;
            words_checked   = 0;
        end
        else
        begin
            // The result taken now always stems from an earlier byte, so it
            // is compared before this edge's byte adds its expectations.
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual 0x%0h", $time, result);
                    fail_count++;
                end
                else
                begin
                    wanted = owed_results.pop_front();
                    check_field("action", wanted.action, result.action);
                    check_field("telemetry_enable", wanted.telemetry_enable,
                                result.telemetry_enable);
                    check_field("readback_request", wanted.readback_request,
                                result.readback_request);
                    check_field("beep_pulse", wanted.beep_pulse, result.beep_pulse);
                    check_field("param_index", wanted.param_index, result.param_index);
                    check_field("param_word", wanted.param_word, result.param_word);
                    check_field("last", wanted.last, result.last);
                    if (wanted.action == ACT_PARAM_WORD)
                        words_checked++;
                    results_checked++;
                end
            end
            if (item_valid && !item_stall)
                predict_byte(item);
            owed_count = owed_results.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the command and parameter frame receiver. The
// checker beside the block watches both channels, predicts every result and
// hands back its failure count; this module only makes traffic.
module testbench;
    import cpfr_pkg::*;

    // A command byte that the receiver treats as a plain beep.
    localparam logic [7:0] CMD_UNUSED = 8'h34;

    // How the payload of a frame is filled.
    typedef enum {
        FILL_RANDOM,
        FILL_RAMP,
        FILL_ONES
    } fill_kind_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    cpfr_item_t   item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    cpfr_result_t result;

    int fail_count;
    int owed_count;
    int results_checked;
    int words_checked;

    // Percent chance that the sender inserts an idle cycle before a byte and
    // that the sink stalls in a given cycle.
    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    int bytes_sent = 0;
    int frames_sent = 0;
    int frames_dropped = 0;

    always #1 clk = ~clk;

    command_and_parameter_frame_receiver_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    frame_receiver_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .fail_count      (fail_count),
        .owed_count      (owed_count),
        .results_checked (results_checked),
        .words_checked   (words_checked)
    );

    // The sink stalls at random, independent of whether a result is waiting,
    // so stalls land on single results and in the middle of word bursts.
    always @(posedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99) < sink_stall_pct);
    end

    // Presents one byte and returns on the edge where its transfer happens.
    // Valid stays high afterwards; the next call either lowers it for an
    // idle cycle or replaces the payload, so each edge sees one assignment.
    task automatic send_byte(input logic [7:0] value, input logic stopped);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{rx_byte: value, car_stopped: stopped};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Opens a frame, sends the full payload and ends it with the given
    // trailer. Payload bytes that look like commands or trailers must be
    // stored as data, so the random fill seeds them in on purpose.
    task automatic send_frame(input logic [7:0] trailer, input fill_kind_t fill);
        int         k;
        logic [7:0] value;
        send_byte(CMD_FRAME, 1'($urandom_range(1)));
        for (k = 0; k < PAYLOAD_BYTES; k++)
        begin
            case (fill)
                FILL_RAMP: value = 8'(k * 37 + 1);
                FILL_ONES: value = 8'hFF;
                default:
                begin
                    case ($urandom_range(15))
                        0:       value = FRAME_TRAILER;
                        1:       value = CMD_FRAME;
                        2:       value = 8'h00;
                        3:       value = 8'hFF;
                        default: value = 8'($urandom_range(255));
                    endcase
                end
            endcase
            send_byte(value, 1'($urandom_range(1)));
        end
        send_byte(trailer, 1'($urandom_range(1)));
        frames_sent++;
        if (trailer != FRAME_TRAILER)
            frames_dropped++;
    endtask

    // A command byte while idle: mostly the defined commands, sometimes the
    // unused code or the trailer code, which only beep, or a random byte.
    task automatic send_command();
        logic [7:0] value;
        case ($urandom_range(9))
            0, 1:    value = CMD_START_STOP;
            2, 3:    value = CMD_TELEMETRY;
            4:       value = CMD_READBACK;
            5:       value = CMD_UNUSED;
            6:       value = FRAME_TRAILER;
            default: value = 8'($urandom_range(255));
        endcase
        // A random byte may happen to be the frame command; then it is replaced
        // by the unused code so the mix stays well formed.
        if (value == CMD_FRAME)
            value = CMD_UNUSED;
        send_byte(value, 1'($urandom_range(1)));
    endtask

    // Random traffic: commands mixed with complete frames, some of them with
    // a broken trailer. A frame is only started when it fits in the budget.
    task automatic run_random(input int byte_budget);
        int         start_count;
        int         pick;
        logic [7:0] bad_trailer;
        start_count = bytes_sent;
        while (bytes_sent - start_count < byte_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 60
                || bytes_sent - start_count + PAYLOAD_BYTES + 2 > byte_budget)
            begin
                send_command();
            end
            else if (pick < 92)
            begin
                send_frame(FRAME_TRAILER, FILL_RANDOM);
            end
            else
            begin
                bad_trailer = 8'($urandom_range(255));
                if (bad_trailer == FRAME_TRAILER)
                    bad_trailer = ~FRAME_TRAILER;
                send_frame(bad_trailer, FILL_RANDOM);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First setting: a sparse sender and a sink that stalls most cycles.
        send_idle_pct  = 32;
        sink_stall_pct = 84;

        // Directed part: both start/stop outcomes, both telemetry toggles,
        // readback, bytes that only beep (including the trailer code while
        // idle), the byte extremes, a good frame with a ramp payload and a
        // frame dropped because its trailer is the frame command, each
        // followed by a command to show the receiver is idle again.
        send_byte(CMD_START_STOP, 1'b1);
        send_byte(CMD_START_STOP, 1'b0);
        send_byte(CMD_TELEMETRY, 1'b0);
        send_byte(CMD_READBACK, 1'b1);
        send_byte(CMD_UNUSED, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(FRAME_TRAILER, 1'b1);
        send_frame(FRAME_TRAILER, FILL_RAMP);
        send_byte(CMD_TELEMETRY, 1'b1);
        send_frame(CMD_FRAME, FILL_RAMP);
        send_byte(CMD_START_STOP, 1'b1);
        send_byte(CMD_READBACK, 1'b0);

        run_random(8);

        // Second setting: the sender is the slow side now.
        send_idle_pct  = 84;
        sink_stall_pct = 32;
        send_frame(FRAME_TRAILER, FILL_ONES);
        run_random(4);

        // Third setting: back to back transfers with no idling at all.
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_frame(FRAME_TRAILER, FILL_RANDOM);
        run_random(4);

        item_valid <= 1'b0;

        // Wait for every predicted result, sampling away from the active
        // edge, then leave room for any stray result the block might add.
        do
            @(negedge clk);
        while (owed_count != 0);
        repeat (24) @(posedge clk);

        $display("Sent %0d bytes including %0d frames (%0d with a bad trailer).",
                 bytes_sent, frames_sent, frames_dropped);
        $display("Checked %0d results, %0d of them parameter words.",
                 results_checked, words_checked);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results still outstanding.", owed_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule
